[design/wgp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the write gather pipe.
// No dependencies; every other design file refers to it by scoped names.
package wgp_pkg;

	localparam int CHUNK_W     = 27;
	localparam int ADDR_W      = 32;
	localparam int DATA_W      = 64;
	localparam int REQ_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [CHUNK_W-1:0] chunk_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	// Write size codes
	typedef enum logic [REQ_W-1:0] {
		REQ_BYTE  = 2'd0,
		REQ_HALF  = 2'd1,
		REQ_WORD  = 2'd2,
		REQ_DWORD = 2'd3
	} req_type_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RING_BASE  = 2'd0,
		REG_RING_END   = 2'd1,
		REG_RING_START = 2'd2
	} reg_idx_t;

endpackage

[design/write_gather_pipe_core.sv]
`timescale 1ns / 1ps
// Write gather pipe: packs CPU writes into bursts and issues them as beats.
// Instantiates wgp_front, wgp_fifo and wgp_back; depends on wgp_pkg.
//
// Input channel: a write of 1, 2, 4 or 8 bytes (req_type, write_data) is
// taken when push is high and full is low, one per cycle. Bytes are appended
// to the gather buffer most significant first.
// Result channel: every BURST_BYTES gathered bytes leave as BURST_BYTES/8
// beats of 64 bits, each with its byte address in the current ring chunk,
// its beat number and a last flag. A beat is shown while empty is low and
// is taken when pop is high.
// Path: the write that completes a burst puts it into the burst queue; its
// beats then pass through the output register, one per cycle while pop is high.
// Throughput: one write per cycle. full rises only when the burst queue
// holds two bursts, which happens when the receiver stalls; the beat
// sequencer emits at most one beat per cycle from the queue head.
// Configuration: cfg_write_en writes ring base, ring end or ring start
// (start loads the ring pointer); write only while the pipe is idle.
// Reset: buffer and queue empty, ring pointer and registers zero.
module write_gather_pipe_core #(
	parameter int BURST_BYTES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [wgp_pkg::REQ_W-1:0]     req_type,
	input  logic [wgp_pkg::DATA_W-1:0]    write_data,
	output logic                          empty,
	input  logic                          pop,
	output logic [wgp_pkg::ADDR_W-1:0]    beat_address,
	output logic [wgp_pkg::DATA_W-1:0]    beat_data,
	output logic [1:0]                    beat_index,
	output logic                          burst_last,
	input  logic                          cfg_write_en,
	input  logic [wgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wgp_pkg::CHUNK_W-1:0]   cfg_data
);

	localparam int BURST_BITS = BURST_BYTES * 8;
	localparam int Q_W        = BURST_BITS + wgp_pkg::ADDR_W;

	logic                   q_full;
	logic                   q_push;
	logic                   q_valid;
	logic                   q_pop;
	logic [BURST_BITS-1:0]  burst_data;
	wgp_pkg::addr_t         burst_addr;
	logic [Q_W-1:0]         q_head;

	wgp_front #(
		.BURST_BYTES(BURST_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.write_data   (write_data),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.burst_valid  (q_push),
		.burst_data   (burst_data),
		.burst_addr   (burst_addr)
	);

	wgp_fifo #(
		.WIDTH(Q_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({burst_data, burst_addr}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head_data (q_head)
	);

	wgp_back #(
		.BURST_BYTES(BURST_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_valid),
		.head_data    (q_head[Q_W-1:wgp_pkg::ADDR_W]),
		.head_addr    (q_head[wgp_pkg::ADDR_W-1:0]),
		.head_pop     (q_pop),
		.empty        (empty),
		.pop          (pop),
		.beat_address (beat_address),
		.beat_data    (beat_data),
		.beat_index   (beat_index),
		.burst_last   (burst_last)
	);

endmodule

[design/wgp_front.sv]
`timescale 1ns / 1ps
// Front end: appends CPU writes to the gather buffer, cuts full bursts and
// owns the ring pointer and its registers. Depends on wgp_pkg.
module wgp_front #(
	parameter int BURST_BYTES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [wgp_pkg::REQ_W-1:0]           req_type,
	input  logic [wgp_pkg::DATA_W-1:0]          write_data,
	input  logic                                cfg_write_en,
	input  logic [wgp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wgp_pkg::CHUNK_W-1:0]         cfg_data,
	input  logic                                q_full,
	output logic                                burst_valid,
	output logic [BURST_BYTES*8-1:0]            burst_data,
	output wgp_pkg::addr_t                      burst_addr
);

	localparam int BEATS = BURST_BYTES / 8;
	localparam int CNT_W = $clog2(BURST_BYTES + 8);
	localparam int WI_W  = CNT_W - 3;

	logic [63:0]           words_q   [BEATS+1];
	logic [63:0]           words_nxt [BEATS+1];
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [3:0]            size;
	logic [63:0]           aligned;
	logic [7:0]            bmask;
	logic [127:0]          shifted;
	logic [15:0]           smask;
	logic [2:0]            off;
	logic [WI_W-1:0]       widx;
	logic                  accept;
	logic                  burst;
	wgp_pkg::chunk_t       chunk_q;
	wgp_pkg::chunk_t       base_q;
	wgp_pkg::chunk_t       end_q;

	assign full        = q_full;
	assign accept      = push && !q_full;
	assign burst_valid = accept && burst;
	assign burst_addr  = wgp_pkg::ADDR_W'(chunk_q) * wgp_pkg::ADDR_W'(BURST_BYTES);

	// Left-align the used bytes so the first byte sits in bits 63:56
	always_comb begin
		unique case (wgp_pkg::req_type_t'(req_type))
			wgp_pkg::REQ_BYTE: begin
				size    = 4'd1;
				aligned = {write_data[7:0], 56'd0};
				bmask   = 8'h80;
			end
			wgp_pkg::REQ_HALF: begin
				size    = 4'd2;
				aligned = {write_data[15:0], 48'd0};
				bmask   = 8'hC0;
			end
			wgp_pkg::REQ_WORD: begin
				size    = 4'd4;
				aligned = {write_data[31:0], 32'd0};
				bmask   = 8'hF0;
			end
			wgp_pkg::REQ_DWORD: begin
				size    = 4'd8;
				aligned = write_data;
				bmask   = 8'hFF;
			end
		endcase
	end

	always_comb begin
		off       = count_q[2:0];
		widx      = count_q[CNT_W-1:3];
		shifted   = {aligned, 64'd0} >> {off, 3'b000};
		smask     = {bmask, 8'd0} >> off;
		count_nxt = count_q + CNT_W'(size);
		burst     = count_nxt >= CNT_W'(BURST_BYTES);
		for (int j = 0; j <= BEATS; j++) begin
			words_nxt[j] = words_q[j];
			for (int k = 0; k < 8; k++) begin
				if (widx == WI_W'(j) && smask[15-k])
					words_nxt[j][63-8*k -: 8] = shifted[127-8*k -: 8];
				if (j > 0 && widx == WI_W'(j-1) && smask[7-k])
					words_nxt[j][63-8*k -: 8] = shifted[63-8*k -: 8];
			end
		end
		for (int b = 0; b < BEATS; b++)
			burst_data[b*64 +: 64] = words_nxt[b];
	end

	// Buffer bytes at or above the count are never read, so no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			if (burst) begin
				// move spill word to the front
				words_q[0] <= words_nxt[BEATS];
			end else begin
				for (int j = 0; j <= BEATS; j++)
					words_q[j] <= words_nxt[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= burst ? CNT_W'(count_nxt - CNT_W'(BURST_BYTES)) : count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			end_q   <= '0;
			chunk_q <= '0;
		end else if (cfg_write_en) begin
			unique case (wgp_pkg::reg_idx_t'(cfg_index))
				wgp_pkg::REG_RING_BASE:  base_q  <= cfg_data;
				wgp_pkg::REG_RING_END:   end_q   <= cfg_data;
				wgp_pkg::REG_RING_START: chunk_q <= cfg_data;
				default: ;
			endcase
		end else if (burst_valid) begin
			// wrap at the end chunk, otherwise step one chunk
			chunk_q <= (chunk_q == end_q) ? base_q : chunk_q + 1'b1;
		end
	end

	a_count_below_burst: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(BURST_BYTES))
		else $error("gather count reached a full burst between transactions");

	a_burst_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid |-> !q_full)
		else $error("burst issued into a full queue");

	a_burst_advances_ring: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid && !cfg_write_en && $past(1'b1) |=>
			(chunk_q == $past(base_q) || chunk_q == $past(chunk_q) + 1'b1))
		else $error("ring pointer did not advance after a burst");

endmodule

[design/wgp_fifo.sv]
`timescale 1ns / 1ps
// Short burst queue between the gather front end and the beat sequencer.
// Depends on wgp_pkg for its depth.
module wgp_fifo #(
	parameter int WIDTH = 288
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int DEPTH = wgp_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign valid     = count_q != '0;
	assign head_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop)
				count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("burst queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid))
		else $error("burst queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("burst queue count out of range");

endmodule

[design/wgp_back.sv]
`timescale 1ns / 1ps
// Back end: walks the head burst one 64-bit beat per cycle into the output
// register whenever it is empty or being popped. Depends on wgp_pkg.
module wgp_back #(
	parameter int BURST_BYTES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  logic [BURST_BYTES*8-1:0]   head_data,
	input  wgp_pkg::addr_t             head_addr,
	output logic                       head_pop,
	output logic                       empty,
	input  logic                       pop,
	output wgp_pkg::addr_t             beat_address,
	output logic [wgp_pkg::DATA_W-1:0] beat_data,
	output logic [1:0]                 beat_index,
	output logic                       burst_last
);

	localparam int BEATS  = BURST_BYTES / 8;
	localparam int BEAT_W = (BEATS > 1) ? $clog2(BEATS) : 1;

	logic [BEAT_W-1:0]   beat_q;
	logic [BEAT_W+1:0]   beat_ext;
	logic                out_valid_q;
	logic                load;
	logic                last_beat;

	assign empty     = !out_valid_q;
	assign load      = head_valid && (!out_valid_q || pop);
	assign last_beat = beat_q == BEAT_W'(BEATS - 1);
	assign head_pop  = load && last_beat;
	assign beat_ext  = {2'b00, beat_q};

	always_ff @(posedge clk) begin
		if (load) begin
			beat_address <= head_addr + wgp_pkg::ADDR_W'({beat_q, 3'b000});
			beat_data    <= head_data[beat_q*64 +: 64];
			beat_index   <= beat_ext[1:0];
			burst_last   <= last_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				beat_q      <= last_beat ? '0 : BEAT_W'(beat_q + 1'b1);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> head_valid && last_beat)
		else $error("burst dropped before its last beat");

	a_burst_held: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q != '0 |-> head_valid)
		else $error("burst left the queue part way through");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_beat |=> beat_q == '0 && burst_last)
		else $error("beat counter did not restart after the last beat");

endmodule
